>>> rtl/core/hdte_pkg.sv
`default_nettype none

package hdte_pkg;

  // minimum string length for a complete date
  localparam int unsigned TEXT_MIN_LEN = 25;
  localparam int unsigned POS_W        = 5;

  // field positions within the string
  localparam logic [POS_W-1:0] POS_DAY    = 5'd5;
  localparam logic [POS_W-1:0] POS_MONTH  = 5'd8;
  localparam logic [POS_W-1:0] POS_YEAR   = 5'd12;
  localparam logic [POS_W-1:0] POS_HOUR   = 5'd17;
  localparam logic [POS_W-1:0] POS_MINUTE = 5'd20;
  localparam logic [POS_W-1:0] POS_SECOND = 5'd23;
  localparam logic [POS_W-1:0] POS_SAT    = 5'(TEXT_MIN_LEN);

  localparam logic [7:0]  CHAR_ZERO = 8'h30;
  localparam logic [7:0]  CHAR_NINE = 8'h39;
  localparam logic [13:0] YEAR_MIN  = 14'd1900;
  localparam int unsigned NUM_MONTHS = 12;

  // result status codes
  localparam logic [1:0] STAT_OK    = 2'd0;
  localparam logic [1:0] STAT_SHORT = 2'd1;
  localparam logic [1:0] STAT_BAD   = 2'd2;

  // controller states
  typedef enum logic [4:0] {
    S_COLLECT = 5'b00001,
    S_DIV     = 5'b00010,
    S_DAYS    = 5'b00100,
    S_MUL     = 5'b01000,
    S_SUM     = 5'b10000
  } state_t;

  // controller to datapath commands
  typedef struct packed {
    logic take_byte;
    logic last;
    logic calc_div;
    logic calc_days;
    logic calc_mul;
    logic load_out;
  } dp_cmd_t;

  // month name plus trailing space, first character in the top byte
  function automatic logic [31:0] month_code(input logic [3:0] idx);
    logic [31:0] code;
    case (idx)
      4'd0:    code = 32'h4A616E20;
      4'd1:    code = 32'h46656220;
      4'd2:    code = 32'h4D617220;
      4'd3:    code = 32'h41707220;
      4'd4:    code = 32'h4D617920;
      4'd5:    code = 32'h4A756E20;
      4'd6:    code = 32'h4A756C20;
      4'd7:    code = 32'h41756720;
      4'd8:    code = 32'h53657020;
      4'd9:    code = 32'h4F637420;
      4'd10:   code = 32'h4E6F7620;
      4'd11:   code = 32'h44656320;
      default: code = 32'h0;
    endcase
    return code;
  endfunction

  // days from March 1 to the first of the month (year starts in March)
  function automatic logic [8:0] month_doy(input logic [3:0] idx);
    logic [8:0] doy;
    case (idx)
      4'd0:    doy = 9'd306;
      4'd1:    doy = 9'd337;
      4'd2:    doy = 9'd0;
      4'd3:    doy = 9'd31;
      4'd4:    doy = 9'd61;
      4'd5:    doy = 9'd92;
      4'd6:    doy = 9'd122;
      4'd7:    doy = 9'd153;
      4'd8:    doy = 9'd184;
      4'd9:    doy = 9'd214;
      4'd10:   doy = 9'd245;
      4'd11:   doy = 9'd275;
      default: doy = 9'd0;
    endcase
    return doy;
  endfunction

endpackage

`default_nettype wire

>>> rtl/core/hdte_ctrl.sv
`default_nettype none

module hdte_ctrl (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  input  wire logic              in_last_byte,
  output logic                   in_ready,
  output logic                   out_valid,
  input  wire logic              out_ready,
  output hdte_pkg::dp_cmd_t      cmd
);

  hdte_pkg::state_t state_r, state_nxt;
  logic             out_valid_r, out_valid_nxt;
  logic             load;

  assign in_ready  = (state_r == hdte_pkg::S_COLLECT);
  assign out_valid = out_valid_r;

  // result loads once the output register is free
  assign load = (state_r == hdte_pkg::S_SUM) && (!out_valid_r || out_ready);

  always_comb begin
    cmd           = '0;
    cmd.take_byte = in_valid && in_ready;
    cmd.last      = in_last_byte;
    cmd.calc_div  = (state_r == hdte_pkg::S_DIV);
    cmd.calc_days = (state_r == hdte_pkg::S_DAYS);
    cmd.calc_mul  = (state_r == hdte_pkg::S_MUL);
    cmd.load_out  = load;
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      hdte_pkg::S_COLLECT: begin
        if (in_valid && in_last_byte) state_nxt = hdte_pkg::S_DIV;
      end
      hdte_pkg::S_DIV:  state_nxt = hdte_pkg::S_DAYS;
      hdte_pkg::S_DAYS: state_nxt = hdte_pkg::S_MUL;
      hdte_pkg::S_MUL:  state_nxt = hdte_pkg::S_SUM;
      hdte_pkg::S_SUM: begin
        if (load) state_nxt = hdte_pkg::S_COLLECT;
      end
      default: state_nxt = hdte_pkg::S_COLLECT;
    endcase
  end

  // output valid flag
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (load) out_valid_nxt = 1'b1;
    else if (out_ready) out_valid_nxt = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= hdte_pkg::S_COLLECT;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

`ifndef SYNTH
  // the final byte stops intake until its result is loaded
  a_last_stops_intake: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready && in_last_byte) |=> !in_ready)
    else $error("input still ready after final byte");

  // a new result appears only out of the summing step
  a_valid_from_sum: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == hdte_pkg::S_SUM))
    else $error("result valid without summing step");

  // arithmetic takes exactly three steps before summing
  a_calc_sequence: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == hdte_pkg::S_DIV) |=> ##1 (state_r == hdte_pkg::S_MUL) ##1
    (state_r == hdte_pkg::S_SUM))
    else $error("arithmetic sequence broken");

  // a pending result is never overwritten
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_ready) |-> !load)
    else $error("pending result overwritten");
`endif

endmodule

`default_nettype wire

>>> rtl/core/hdte_dp.sv
`default_nettype none

module hdte_dp (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire hdte_pkg::dp_cmd_t   cmd,
  input  wire logic [7:0]          text_byte,
  output logic signed [38:0]       epoch_seconds,
  output logic [1:0]               status
);

  // parse state
  logic [hdte_pkg::POS_W-1:0] pos_r, pos_nxt;
  logic [6:0]  day_r, day_nxt;
  logic [6:0]  hour_r, hour_nxt;
  logic [6:0]  min_r, min_nxt;
  logic [6:0]  sec_r, sec_nxt;
  logic [13:0] year_r, year_nxt;
  logic [31:0] month_r, month_nxt;
  logic        bad_r, bad_nxt;

  // arithmetic stages
  logic [13:0]        yy_r;
  logic [6:0]         q100_r;
  logic [18:0]        hms_r;
  logic [1:0]         stat_r;
  logic [8:0]         doy_r;
  logic signed [23:0] days_r;
  logic [38:0]        secs_r;
  logic signed [38:0] epoch_r;
  logic [1:0]         status_r;

  logic        is_digit;
  logic [3:0]  digit;
  logic        month_ok;
  logic [3:0]  month_idx;
  logic [13:0] yy;
  logic [26:0] q_prod;
  logic [18:0] hms;
  logic [1:0]  stat;
  logic [23:0] days_pos;
  logic [23:0] days_neg;
  logic signed [41:0] mul_prod;

  assign is_digit = (text_byte >= hdte_pkg::CHAR_ZERO) && (text_byte <= hdte_pkg::CHAR_NINE);
  assign digit    = 4'(text_byte - hdte_pkg::CHAR_ZERO);

  // byte capture at the fixed field positions
  always_comb begin
    pos_nxt   = pos_r;
    day_nxt   = day_r;
    hour_nxt  = hour_r;
    min_nxt   = min_r;
    sec_nxt   = sec_r;
    year_nxt  = year_r;
    month_nxt = month_r;
    bad_nxt   = bad_r;
    if (cmd.load_out) begin
      pos_nxt   = '0;
      day_nxt   = '0;
      hour_nxt  = '0;
      min_nxt   = '0;
      sec_nxt   = '0;
      year_nxt  = '0;
      month_nxt = '0;
      bad_nxt   = 1'b0;
    end else if (cmd.take_byte) begin
      case (pos_r) inside
        [hdte_pkg::POS_DAY:hdte_pkg::POS_DAY + 5'd1]: begin
          if (is_digit) day_nxt = 7'(day_r * 7'd10 + 7'(digit));
          else bad_nxt = 1'b1;
        end
        [hdte_pkg::POS_MONTH:hdte_pkg::POS_MONTH + 5'd3]: begin
          month_nxt = {month_r[23:0], text_byte};
        end
        [hdte_pkg::POS_YEAR:hdte_pkg::POS_YEAR + 5'd3]: begin
          if (is_digit) year_nxt = 14'(year_r * 14'd10 + 14'(digit));
          else bad_nxt = 1'b1;
        end
        [hdte_pkg::POS_HOUR:hdte_pkg::POS_HOUR + 5'd1]: begin
          if (is_digit) hour_nxt = 7'(hour_r * 7'd10 + 7'(digit));
          else bad_nxt = 1'b1;
        end
        [hdte_pkg::POS_MINUTE:hdte_pkg::POS_MINUTE + 5'd1]: begin
          if (is_digit) min_nxt = 7'(min_r * 7'd10 + 7'(digit));
          else bad_nxt = 1'b1;
        end
        [hdte_pkg::POS_SECOND:hdte_pkg::POS_SECOND + 5'd1]: begin
          if (is_digit) sec_nxt = 7'(sec_r * 7'd10 + 7'(digit));
          else bad_nxt = 1'b1;
        end
        default: ;
      endcase
      // position holds on the final byte and saturates at POS_SAT; it gives the string length minus one
      if (!cmd.last && (pos_r < hdte_pkg::POS_SAT)) pos_nxt = pos_r + 5'd1;
    end
  end

  // month name lookup
  always_comb begin
    month_ok  = 1'b0;
    month_idx = '0;
    for (int i = 0; i < hdte_pkg::NUM_MONTHS; i++) begin
      if (month_r == hdte_pkg::month_code(4'(i))) begin
        month_ok  = 1'b1;
        month_idx = 4'(i);
      end
    end
  end

  // January and February count with the previous year
  assign yy     = year_r - 14'(month_idx < 4'd2);
  // yy / 100 by reciprocal, exact below 43699
  assign q_prod = 27'(yy) * 27'd5243;
  assign hms    = 19'(hour_r) * 19'd3600 + 19'(min_r) * 19'd60 + 19'(sec_r);

  always_comb begin
    if (pos_r < hdte_pkg::POS_SAT - 5'd1) stat = hdte_pkg::STAT_SHORT;
    else if (bad_r || !month_ok || (year_r < hdte_pkg::YEAR_MIN)) stat = hdte_pkg::STAT_BAD;
    else stat = hdte_pkg::STAT_OK;
  end

  // days: yy*365 + yy/4 - yy/100 + yy/400 + doy + day - 1 - 719468
  assign days_pos = 24'(yy_r) * 24'd365 + 24'(yy_r >> 2) + 24'(q100_r >> 2)
                  + 24'(doy_r) + 24'(day_r);
  assign days_neg = 24'(q100_r) + 24'd719469;
  assign mul_prod = $signed({{18{days_r[23]}}, days_r}) * $signed(42'sd86400);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r   <= '0;
      day_r   <= '0;
      hour_r  <= '0;
      min_r   <= '0;
      sec_r   <= '0;
      year_r  <= '0;
      month_r <= '0;
      bad_r   <= 1'b0;
    end else begin
      pos_r   <= pos_nxt;
      day_r   <= day_nxt;
      hour_r  <= hour_nxt;
      min_r   <= min_nxt;
      sec_r   <= sec_nxt;
      year_r  <= year_nxt;
      month_r <= month_nxt;
      bad_r   <= bad_nxt;
    end
  end

  // arithmetic pipeline steps, enabled by the controller
  always_ff @(posedge clk) begin
    if (cmd.calc_div) begin
      yy_r   <= yy;
      q100_r <= q_prod[25:19];
      hms_r  <= hms;
      stat_r <= stat;
      doy_r  <= hdte_pkg::month_doy(month_idx);
    end
    if (cmd.calc_days) days_r <= $signed(days_pos - days_neg);
    if (cmd.calc_mul)  secs_r <= mul_prod[38:0];
    if (cmd.load_out) begin
      status_r <= stat_r;
      epoch_r  <= (stat_r == hdte_pkg::STAT_OK) ? $signed(secs_r + 39'(hms_r)) : '0;
    end
  end

  assign epoch_seconds = epoch_r;
  assign status        = status_r;

endmodule

`default_nettype wire

>>> rtl/core/http_date_text_to_epoch_core.sv
// Channel  | Ports                                  | Direction
// input    | in_valid, in_ready, in_text_byte,      | in (ready out)
//          | in_last_byte                           |
// result   | out_valid, out_ready,                  | out (ready in)
//          | out_epoch_seconds, out_status          |
//
// One byte is taken per cycle while a string is collected.
// After the final byte, the date arithmetic steps (divide, day count,
// multiply by 86400, sum) run in that order before the result loads.
// The 24x18 day multiplier sets the step length.
// Intake stops from the final byte until its result loads; a stalled output
// holds the result and the summing step waits for it to drain.
// Reset is synchronous, active low, and clears the parse state.
`default_nettype none

module http_date_text_to_epoch_core (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire logic [7:0]         in_text_byte,
  input  wire logic               in_last_byte,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output logic signed [38:0]      out_epoch_seconds,
  output logic [1:0]              out_status
);

  hdte_pkg::dp_cmd_t cmd;

  // control
  hdte_ctrl u_ctrl (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_last_byte (in_last_byte),
    .in_ready     (in_ready),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .cmd          (cmd)
  );

  // parse and arithmetic
  hdte_dp u_dp (
    .clk           (clk),
    .rst_n         (rst_n),
    .cmd           (cmd),
    .text_byte     (in_text_byte),
    .epoch_seconds (out_epoch_seconds),
    .status        (out_status)
  );

endmodule

`default_nettype wire
